>>> hw/rtl/rsas_pkg.sv
// Shared types and constants of the ray-sphere character shader.
`default_nettype none

package rsas_pkg;

    localparam int FRAC_BITS       = 15;
    localparam int MAX_DIM         = 256;
    localparam int GRADIENT_LEVELS = 17;
    localparam int SHADE_SCALE     = 20;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [4:0] SHADE_MAX = 5'(GRADIENT_LEVELS - 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COL_COUNT     = 3'd0,
        REG_ROW_COUNT     = 3'd1,
        REG_SPHERE_RADIUS = 3'd2,
        REG_LIGHT_X       = 3'd3,
        REG_LIGHT_Y       = 3'd4,
        REG_LIGHT_Z       = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic        [8:0]  col_count;
        logic        [8:0]  row_count;
        logic        [14:0] sphere_radius;
        logic signed [15:0] light_x;
        logic signed [15:0] light_y;
        logic signed [15:0] light_z;
    } t_cfg;

    typedef struct packed {
        logic [7:0] pixel_char;
        logic [4:0] shade_index;
        logic       hit;
    } t_result;

endpackage

`default_nettype wire

>>> hw/rtl/rsas_if.sv
// Request channels of the shader: pixel in, character out, register writes.
`default_nettype none

interface rsas_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] col;
    logic [7:0] row;

    modport source (output valid, output col, output row, input ready);
    modport sink   (input valid, input col, input row, output ready);
endinterface

interface rsas_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_char;
    logic [4:0] shade_index;
    logic       hit;

    modport source (output valid, output pixel_char, output shade_index, output hit,
                    input ready);
    modport sink   (input valid, input pixel_char, input shade_index, input hit,
                    output ready);
endinterface

interface rsas_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/rsas_pipe.sv
// Shading datapath: coordinate divide, three square roots, two divides, dot product.
`default_nettype none

module rsas_pipe
    import rsas_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_en,
    input  logic    i_valid,
    input  logic    [7:0] i_col,
    input  logic    [7:0] i_row,
    input  t_cfg    i_cfg,
    output logic    o_valid,
    output t_result o_res
);

    localparam int DIV_STEPS  = 15;
    localparam int SQRT_STEPS = 17;
    localparam int DEPTH      = 3 * (DIV_STEPS + 1) + 3 * (SQRT_STEPS + 1) + 9;

    typedef struct packed {
        logic [17:0] rem;
        logic [14:0] q;
    } t_div;

    typedef struct packed {
        logic [33:0] x;
        logic [19:0] rem;
        logic [16:0] root;
    } t_sqrt;

    typedef struct packed {
        t_div du;
        t_div dv;
        logic neg_u;
        logic sat_u;
        logic neg_v;
        logic sat_v;
    } t_uv;

    typedef struct packed {
        logic [15:0] mu;
        logic [15:0] mv;
        logic        neg_u;
        logic        neg_v;
        logic [30:0] usq;
        logic [30:0] vsq;
    } t_sq1;

    typedef struct packed {
        t_sqrt       sq;
        logic [15:0] mu;
        logic [15:0] mv;
        logic        neg_u;
        logic        neg_v;
    } t_len;

    typedef struct packed {
        t_div        dx;
        t_div        dy;
        t_div        dz;
        logic        hx;
        logic        hy;
        logic        hz;
        logic        neg_y;
        logic        neg_z;
        logic [16:0] dvs;
    } t_dd;

    typedef struct packed {
        logic [15:0] dx;
        logic [15:0] my;
        logic [15:0] mz;
        logic        neg_y;
        logic        neg_z;
        logic [30:0] dxsq;
        logic [31:0] radsq;
    } t_h1;

    typedef struct packed {
        t_sqrt       sq;
        logic [15:0] dx;
        logic [15:0] my;
        logic [15:0] mz;
        logic        neg_y;
        logic        neg_z;
        logic        hpos;
    } t_s2;

    typedef struct packed {
        logic [15:0] dx;
        logic [15:0] my;
        logic [15:0] mz;
        logic        neg_y;
        logic        neg_z;
        logic        hit;
        logic [16:0] tp;
    } t_tt;

    typedef struct packed {
        logic [31:0] prx;
        logic [31:0] pry;
        logic [31:0] prz;
        logic        neg_y;
        logic        neg_z;
        logic        hit;
    } t_p1;

    typedef struct packed {
        logic [16:0] mx;
        logic [16:0] my;
        logic [16:0] mz;
        logic        neg_y;
        logic        neg_z;
        logic        hit;
    } t_p2;

    typedef struct packed {
        logic [16:0] mx;
        logic [16:0] my;
        logic [16:0] mz;
        logic        neg_y;
        logic        neg_z;
        logic        hit;
        logic [32:0] sx;
        logic [32:0] sy;
        logic [32:0] sz;
    } t_p3;

    typedef struct packed {
        t_sqrt       sq;
        logic [16:0] mx;
        logic [16:0] my;
        logic [16:0] mz;
        logic        neg_y;
        logic        neg_z;
        logic        hit;
    } t_s3;

    typedef struct packed {
        t_div        nx;
        t_div        ny;
        t_div        nz;
        logic        hx;
        logic        hy;
        logic        hz;
        logic        neg_y;
        logic        neg_z;
        logic        hit;
        logic        pzero;
        logic [16:0] dvs;
    } t_nd;

    typedef struct packed {
        logic signed [32:0] px;
        logic signed [32:0] py;
        logic signed [32:0] pz;
        logic               hit;
        logic               pzero;
    } t_lp;

    typedef struct packed {
        logic signed [34:0] d;
        logic               hit;
        logic               pzero;
    } t_dot;

    // restoring divide, one quotient bit; expects rem below divisor
    function automatic t_div div_step(t_div s, logic [16:0] dvs);
        logic [17:0] r2;
        t_div        o;
        r2 = {s.rem[16:0], 1'b0};
        if (r2 >= {1'b0, dvs}) begin
            o.rem = r2 - {1'b0, dvs};
            o.q   = {s.q[13:0], 1'b1};
        end else begin
            o.rem = r2;
            o.q   = {s.q[13:0], 1'b0};
        end
        return o;
    endfunction

    // first quotient bit where dividend top part may equal the divisor
    function automatic t_div div_first(logic [16:0] a, logic [16:0] dvs);
        t_div o;
        o.q   = '0;
        o.rem = (a >= dvs) ? {1'b0, a - dvs} : {1'b0, a};
        return o;
    endfunction

    // integer square root, two radicand bits per step
    function automatic t_sqrt sqrt_step(t_sqrt s);
        logic [21:0] pre;
        logic [21:0] trial;
        t_sqrt       o;
        pre   = {s.rem, s.x[33:32]};
        trial = {3'b000, s.root, 2'b01};
        o.x   = {s.x[31:0], 2'b00};
        if (pre >= trial) begin
            o.rem  = 20'(pre - trial);
            o.root = {s.root[15:0], 1'b1};
        end else begin
            o.rem  = pre[19:0];
            o.root = {s.root[15:0], 1'b0};
        end
        return o;
    endfunction

    function automatic t_sqrt sqrt_init(logic [33:0] x);
        t_sqrt o;
        o.x    = x;
        o.rem  = '0;
        o.root = '0;
        return o;
    endfunction

    function automatic logic [8:0] clamp_dim(logic [8:0] n);
        logic [8:0] c;
        if (n == '0) begin
            c = 9'd1;
        end else if (n > 9'(MAX_DIM)) begin
            c = 9'(MAX_DIM);
        end else begin
            c = n;
        end
        return c;
    endfunction

    function automatic logic [7:0] shade_char(logic [4:0] idx);
        logic [7:0] ch;
        case (idx)
            5'd1:    ch = 8'h2E; // .
            5'd2:    ch = 8'h3A; // :
            5'd3:    ch = 8'h21; // !
            5'd4:    ch = 8'h2F; // /
            5'd5:    ch = 8'h72; // r
            5'd6:    ch = 8'h28; // (
            5'd7:    ch = 8'h6C; // l
            5'd8:    ch = 8'h31; // 1
            5'd9:    ch = 8'h5A; // Z
            5'd10:   ch = 8'h34; // 4
            5'd11:   ch = 8'h48; // H
            default: ch = 8'h20;
        endcase
        return ch;
    endfunction

    logic [8:0] cc;
    logic [8:0] cr;

    assign cc = clamp_dim(i_cfg.col_count);
    assign cr = clamp_dim(i_cfg.row_count);

    t_uv     r_uv  [0:DIV_STEPS];
    t_sq1    r_sq1;
    t_uv     n_uv0;
    t_len    r_len [0:SQRT_STEPS];
    t_len    n_len0;
    t_dd     r_dd  [0:DIV_STEPS];
    t_dd     n_dd0;
    t_h1     r_h1;
    t_h1     n_h1;
    t_s2     r_s2  [0:SQRT_STEPS];
    t_s2     n_s20;
    t_tt     r_tt;
    t_tt     n_tt;
    t_p1     r_p1;
    t_p1     n_p1;
    t_p2     r_p2;
    t_p2     n_p2;
    t_p3     r_p3;
    t_p3     n_p3;
    t_s3     r_s3  [0:SQRT_STEPS];
    t_s3     n_s30;
    t_nd     r_nd  [0:DIV_STEPS];
    t_nd     n_nd0;
    t_lp     r_lp;
    t_lp     n_lp;
    t_dot    r_dot;
    t_dot    n_dot;
    t_result r_res;
    t_result n_res;
    t_sq1    n_sq1;
    logic    r_vld [0:DEPTH-1];

    // screen coordinate: |2*pos - c| / c in Q.15, saturated when not below c
    always_comb begin
        logic signed [10:0] diff_u;
        logic signed [10:0] diff_v;
        logic        [9:0]  mag_u;
        logic        [9:0]  mag_v;
        diff_u = $signed({2'b00, i_col, 1'b0}) - $signed({2'b00, cc});
        diff_v = $signed({2'b00, i_row, 1'b0}) - $signed({2'b00, cr});
        mag_u  = diff_u[10] ? 10'(-diff_u) : diff_u[9:0];
        mag_v  = diff_v[10] ? 10'(-diff_v) : diff_v[9:0];
        n_uv0.du.rem = {8'b0, mag_u};
        n_uv0.du.q   = '0;
        n_uv0.dv.rem = {8'b0, mag_v};
        n_uv0.dv.q   = '0;
        n_uv0.neg_u  = diff_u[10];
        n_uv0.neg_v  = diff_v[10];
        n_uv0.sat_u  = (mag_u >= {1'b0, cc});
        n_uv0.sat_v  = (mag_v >= {1'b0, cr});
    end

    always_comb begin
        logic [15:0] mu;
        logic [15:0] mv;
        mu = r_uv[DIV_STEPS].sat_u ? 16'h8000 : {1'b0, r_uv[DIV_STEPS].du.q};
        mv = r_uv[DIV_STEPS].sat_v ? 16'h8000 : {1'b0, r_uv[DIV_STEPS].dv.q};
        n_sq1.mu    = mu;
        n_sq1.mv    = mv;
        n_sq1.neg_u = r_uv[DIV_STEPS].neg_u;
        n_sq1.neg_v = r_uv[DIV_STEPS].neg_v;
        n_sq1.usq   = 31'({16'b0, mu} * {16'b0, mu});
        n_sq1.vsq   = 31'({16'b0, mv} * {16'b0, mv});
    end

    // ray length: sqrt(S^2 + u^2 + v^2)
    always_comb begin
        logic [33:0] sum;
        sum = 34'h0_4000_0000 + {3'b0, r_sq1.usq} + {3'b0, r_sq1.vsq};
        n_len0.sq    = sqrt_init(sum);
        n_len0.mu    = r_sq1.mu;
        n_len0.mv    = r_sq1.mv;
        n_len0.neg_u = r_sq1.neg_u;
        n_len0.neg_v = r_sq1.neg_v;
    end

    // direction = (S, u, v) * S / len; every numerator is at most len
    always_comb begin
        logic [16:0] len;
        len = r_len[SQRT_STEPS].sq.root;
        n_dd0.dvs   = len;
        n_dd0.dx    = div_first(17'h08000, len);
        n_dd0.dy    = div_first({1'b0, r_len[SQRT_STEPS].mu}, len);
        n_dd0.dz    = div_first({1'b0, r_len[SQRT_STEPS].mv}, len);
        n_dd0.hx    = (17'h08000 >= len);
        n_dd0.hy    = ({1'b0, r_len[SQRT_STEPS].mu} >= len);
        n_dd0.hz    = ({1'b0, r_len[SQRT_STEPS].mv} >= len);
        n_dd0.neg_y = r_len[SQRT_STEPS].neg_u;
        n_dd0.neg_z = r_len[SQRT_STEPS].neg_v;
    end

    always_comb begin
        logic [15:0] dx;
        logic [15:0] rad;
        dx  = {r_dd[DIV_STEPS].hx, r_dd[DIV_STEPS].dx.q};
        rad = {i_cfg.sphere_radius, 1'b0}; // Q1.14 radius to Q.15
        n_h1.dx    = dx;
        n_h1.my    = {r_dd[DIV_STEPS].hy, r_dd[DIV_STEPS].dy.q};
        n_h1.mz    = {r_dd[DIV_STEPS].hz, r_dd[DIV_STEPS].dz.q};
        n_h1.neg_y = r_dd[DIV_STEPS].neg_y;
        n_h1.neg_z = r_dd[DIV_STEPS].neg_z;
        n_h1.dxsq  = 31'({16'b0, dx} * {16'b0, dx});
        n_h1.radsq = {16'b0, rad} * {16'b0, rad};
    end

    // discriminant h = 4dx^2 - 4S^2 + R^2
    always_comb begin
        logic signed [34:0] h;
        h = $signed({2'b00, r_h1.dxsq, 2'b00}) - $signed(35'h1_0000_0000)
            + $signed({3'b000, r_h1.radsq});
        n_s20.sq    = sqrt_init(h[34] ? 34'd0 : h[33:0]);
        n_s20.dx    = r_h1.dx;
        n_s20.my    = r_h1.my;
        n_s20.mz    = r_h1.mz;
        n_s20.neg_y = r_h1.neg_y;
        n_s20.neg_z = r_h1.neg_z;
        n_s20.hpos  = !h[34];
    end

    always_comb begin
        logic signed [17:0] t;
        t = $signed({1'b0, r_s2[SQRT_STEPS].dx, 1'b0})
            - $signed({1'b0, r_s2[SQRT_STEPS].sq.root});
        n_tt.dx    = r_s2[SQRT_STEPS].dx;
        n_tt.my    = r_s2[SQRT_STEPS].my;
        n_tt.mz    = r_s2[SQRT_STEPS].mz;
        n_tt.neg_y = r_s2[SQRT_STEPS].neg_y;
        n_tt.neg_z = r_s2[SQRT_STEPS].neg_z;
        n_tt.hit   = r_s2[SQRT_STEPS].hpos && !t[17] && (t != '0);
        n_tt.tp    = t[16:0];
    end

    always_comb begin
        n_p1.prx   = {16'b0, r_tt.dx} * {15'b0, r_tt.tp};
        n_p1.pry   = {16'b0, r_tt.my} * {15'b0, r_tt.tp};
        n_p1.prz   = {16'b0, r_tt.mz} * {15'b0, r_tt.tp};
        n_p1.neg_y = r_tt.neg_y;
        n_p1.neg_z = r_tt.neg_z;
        n_p1.hit   = r_tt.hit;
    end

    // hit point; px = -2S + dx*t/S is never positive
    always_comb begin
        n_p2.mx    = 17'h10000 - r_p1.prx[31:15];
        n_p2.my    = r_p1.pry[31:15];
        n_p2.mz    = r_p1.prz[31:15];
        n_p2.neg_y = r_p1.neg_y;
        n_p2.neg_z = r_p1.neg_z;
        n_p2.hit   = r_p1.hit;
    end

    always_comb begin
        n_p3.mx    = r_p2.mx;
        n_p3.my    = r_p2.my;
        n_p3.mz    = r_p2.mz;
        n_p3.neg_y = r_p2.neg_y;
        n_p3.neg_z = r_p2.neg_z;
        n_p3.hit   = r_p2.hit;
        n_p3.sx    = {16'b0, r_p2.mx} * {16'b0, r_p2.mx};
        n_p3.sy    = {16'b0, r_p2.my} * {16'b0, r_p2.my};
        n_p3.sz    = {16'b0, r_p2.mz} * {16'b0, r_p2.mz};
    end

    always_comb begin
        logic [33:0] sum;
        sum = {1'b0, r_p3.sx} + {1'b0, r_p3.sy} + {1'b0, r_p3.sz};
        n_s30.sq    = sqrt_init(sum);
        n_s30.mx    = r_p3.mx;
        n_s30.my    = r_p3.my;
        n_s30.mz    = r_p3.mz;
        n_s30.neg_y = r_p3.neg_y;
        n_s30.neg_z = r_p3.neg_z;
        n_s30.hit   = r_p3.hit;
    end

    // normal = p * S / |p|; a zero length is flagged and divided by one
    always_comb begin
        logic [16:0] plen;
        logic [16:0] dvs;
        plen = r_s3[SQRT_STEPS].sq.root;
        dvs  = (plen == '0) ? 17'd1 : plen;
        n_nd0.dvs   = dvs;
        n_nd0.nx    = div_first(r_s3[SQRT_STEPS].mx, dvs);
        n_nd0.ny    = div_first(r_s3[SQRT_STEPS].my, dvs);
        n_nd0.nz    = div_first(r_s3[SQRT_STEPS].mz, dvs);
        n_nd0.hx    = (r_s3[SQRT_STEPS].mx >= dvs);
        n_nd0.hy    = (r_s3[SQRT_STEPS].my >= dvs);
        n_nd0.hz    = (r_s3[SQRT_STEPS].mz >= dvs);
        n_nd0.neg_y = r_s3[SQRT_STEPS].neg_y;
        n_nd0.neg_z = r_s3[SQRT_STEPS].neg_z;
        n_nd0.hit   = r_s3[SQRT_STEPS].hit;
        n_nd0.pzero = (plen == '0);
    end

    always_comb begin
        logic signed [16:0] nx;
        logic signed [16:0] ny;
        logic signed [16:0] nz;
        logic signed [16:0] my;
        logic signed [16:0] mz;
        nx = -$signed({1'b0, r_nd[DIV_STEPS].hx, r_nd[DIV_STEPS].nx.q});
        my = $signed({1'b0, r_nd[DIV_STEPS].hy, r_nd[DIV_STEPS].ny.q});
        mz = $signed({1'b0, r_nd[DIV_STEPS].hz, r_nd[DIV_STEPS].nz.q});
        ny = r_nd[DIV_STEPS].neg_y ? -my : my;
        nz = r_nd[DIV_STEPS].neg_z ? -mz : mz;
        n_lp.px    = 33'(nx) * 33'(i_cfg.light_x);
        n_lp.py    = 33'(ny) * 33'(i_cfg.light_y);
        n_lp.pz    = 33'(nz) * 33'(i_cfg.light_z);
        n_lp.hit   = r_nd[DIV_STEPS].hit;
        n_lp.pzero = r_nd[DIV_STEPS].pzero;
    end

    always_comb begin
        n_dot.d = {{2{r_lp.px[32]}}, r_lp.px} + {{2{r_lp.py[32]}}, r_lp.py}
                  + {{2{r_lp.pz[32]}}, r_lp.pz};
        n_dot.hit   = r_lp.hit;
        n_dot.pzero = r_lp.pzero;
    end

    // index = (20 * d) >> 30, clamped
    always_comb begin
        logic [31:0] dm;
        logic [36:0] scaled;
        logic [6:0]  lvl;
        logic [4:0]  idx;
        dm     = r_dot.d[31:0];
        scaled = {1'b0, dm, 4'b0000} + {3'b000, dm, 2'b00};
        lvl    = scaled[36:30];
        if (r_dot.hit && !r_dot.pzero && !r_dot.d[34] && (r_dot.d != '0)) begin
            idx = (lvl > {2'b00, SHADE_MAX}) ? SHADE_MAX : lvl[4:0];
        end else begin
            idx = '0;
        end
        n_res.shade_index = idx;
        n_res.pixel_char  = shade_char(idx);
        n_res.hit         = r_dot.hit;
    end

    always_ff @(posedge i_clk) begin
        t_uv  n_uv;
        t_len n_len;
        t_dd  n_dd;
        t_s2  n_s2;
        t_s3  n_s3;
        t_nd  n_nd;
        if (i_en) begin
            r_uv[0] <= n_uv0;
            for (int k = 1; k <= DIV_STEPS; k++) begin
                n_uv    = r_uv[k-1];
                n_uv.du = div_step(r_uv[k-1].du, {8'b0, cc});
                n_uv.dv = div_step(r_uv[k-1].dv, {8'b0, cr});
                r_uv[k] <= n_uv;
            end
            r_sq1 <= n_sq1;
            r_len[0] <= n_len0;
            for (int k = 1; k <= SQRT_STEPS; k++) begin
                n_len    = r_len[k-1];
                n_len.sq = sqrt_step(r_len[k-1].sq);
                r_len[k] <= n_len;
            end
            r_dd[0] <= n_dd0;
            for (int k = 1; k <= DIV_STEPS; k++) begin
                n_dd    = r_dd[k-1];
                n_dd.dx = div_step(r_dd[k-1].dx, r_dd[k-1].dvs);
                n_dd.dy = div_step(r_dd[k-1].dy, r_dd[k-1].dvs);
                n_dd.dz = div_step(r_dd[k-1].dz, r_dd[k-1].dvs);
                r_dd[k] <= n_dd;
            end
            r_h1 <= n_h1;
            r_s2[0] <= n_s20;
            for (int k = 1; k <= SQRT_STEPS; k++) begin
                n_s2    = r_s2[k-1];
                n_s2.sq = sqrt_step(r_s2[k-1].sq);
                r_s2[k] <= n_s2;
            end
            r_tt <= n_tt;
            r_p1 <= n_p1;
            r_p2 <= n_p2;
            r_p3 <= n_p3;
            r_s3[0] <= n_s30;
            for (int k = 1; k <= SQRT_STEPS; k++) begin
                n_s3    = r_s3[k-1];
                n_s3.sq = sqrt_step(r_s3[k-1].sq);
                r_s3[k] <= n_s3;
            end
            r_nd[0] <= n_nd0;
            for (int k = 1; k <= DIV_STEPS; k++) begin
                n_nd    = r_nd[k-1];
                n_nd.nx = div_step(r_nd[k-1].nx, r_nd[k-1].dvs);
                n_nd.ny = div_step(r_nd[k-1].ny, r_nd[k-1].dvs);
                n_nd.nz = div_step(r_nd[k-1].nz, r_nd[k-1].dvs);
                r_nd[k] <= n_nd;
            end
            r_lp  <= n_lp;
            r_dot <= n_dot;
            r_res <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DEPTH; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (i_en) begin
            r_vld[0] <= i_valid;
            for (int k = 1; k < DEPTH; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    assign o_valid = r_vld[DEPTH-1];
    assign o_res   = r_res;

endmodule

`default_nettype wire

>>> hw/rtl/ray_sphere_ascii_shader.sv
// Top level of the ray-sphere character shader: registers, datapath and output buffer.
//
// Pixel requests (col, row) enter on i_px; each gives one shaded character on o_px,
// in order. i_cfg writes the screen size, sphere radius and light direction; its
// ready is always high. Writes must be made only while no pixel is in flight; the
// block itself does not enforce it. Each pixel passes a 111-stage datapath (coordinate
// divides, ray length root, direction divides, discriminant root, hit point root,
// normal divides, dot product, gradient lookup) followed by the output register.
// One pixel is accepted per clock while i_px.ready is high; every root and divide
// is unrolled one digit per stage.
// When the receiver stalls, the output register holds its result and one further
// result drops into a skid register; the datapath then freezes in place and
// i_px.ready falls until the skid entry has moved on. Nothing is lost or repeated.
// Synchronous reset empties the datapath and output buffer and loads the default
// configuration: 120 x 30 screen, radius 1.0, light (0, 0.707, -0.707).
`default_nettype none

module ray_sphere_ascii_shader
    import rsas_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    rsas_in_if.sink     i_px,
    rsas_out_if.source  o_px,
    rsas_cfg_if.sink    i_cfg
);

    t_cfg    r_cfg;
    t_result r_out;
    t_result r_skid;
    logic    r_out_vld;
    logic    r_skid_vld;
    logic    pipe_en;
    logic    pipe_vld;
    t_result pipe_res;

    assign pipe_en     = !r_skid_vld;
    assign i_px.ready  = pipe_en;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.col_count     <= 9'd120;
            r_cfg.row_count     <= 9'd30;
            r_cfg.sphere_radius <= 15'd16384;
            r_cfg.light_x       <= 16'sd0;
            r_cfg.light_y       <= 16'sd23170;
            r_cfg.light_z       <= -16'sd23170;
        end else if (i_cfg.valid) begin
            unique case (t_reg_idx'(i_cfg.index))
                REG_COL_COUNT:     r_cfg.col_count     <= i_cfg.data[8:0];
                REG_ROW_COUNT:     r_cfg.row_count     <= i_cfg.data[8:0];
                REG_SPHERE_RADIUS: r_cfg.sphere_radius <= i_cfg.data[14:0];
                REG_LIGHT_X:       r_cfg.light_x       <= $signed(i_cfg.data);
                REG_LIGHT_Y:       r_cfg.light_y       <= $signed(i_cfg.data);
                REG_LIGHT_Z:       r_cfg.light_z       <= $signed(i_cfg.data);
                default: ;
            endcase
        end
    end

    rsas_pipe u_pipe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_valid (i_px.valid),
        .i_col   (i_px.col),
        .i_row   (i_px.row),
        .i_cfg   (r_cfg),
        .o_valid (pipe_vld),
        .o_res   (pipe_res)
    );

    // output register with one skid entry; the datapath stops while the skid is full
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_out_vld && !o_px.ready) begin
            if (pipe_en && pipe_vld) begin
                r_skid_vld <= 1'b1;
            end
        end else if (r_skid_vld) begin
            r_out_vld  <= 1'b1;
            r_skid_vld <= 1'b0;
        end else begin
            r_out_vld <= pipe_en && pipe_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_out_vld && !o_px.ready) begin
            if (pipe_en && pipe_vld) begin
                r_skid <= pipe_res;
            end
        end else if (r_skid_vld) begin
            r_out <= r_skid;
        end else begin
            r_out <= pipe_res;
        end
    end

    assign o_px.valid       = r_out_vld;
    assign o_px.pixel_char  = r_out.pixel_char;
    assign o_px.shade_index = r_out.shade_index;
    assign o_px.hit         = r_out.hit;

endmodule

`default_nettype wire
